[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, suspended while reset is asserted.
`define H2R_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that also runs during reset.
`define H2R_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/h2r_pkg.sv]
// ----------------------------------------------------------------------------
// h2r_pkg
// Types and constants of the HCY to RGB converter.
// ----------------------------------------------------------------------------
package h2r_pkg;

    localparam int HUE_W = 15;
    localparam int CH_W  = 12;

    localparam logic signed [13:0] FULL_S  = 14'sd4095;
    localparam logic signed [12:0] W_RED   = 13'sd1229;
    localparam logic signed [12:0] W_GREEN = 13'sd2417;
    localparam logic signed [12:0] W_BLUE  = 13'sd451;
    localparam logic        [11:0] CH_MAX  = 12'd4095;

    typedef enum logic [2:0] {
        SEXT_RY = 3'd0,
        SEXT_YG = 3'd1,
        SEXT_GC = 3'd2,
        SEXT_CB = 3'd3,
        SEXT_BM = 3'd4,
        SEXT_MR = 3'd5
    } t_sextant;

    // Beat passed from the chroma section to the luma section.
    typedef struct packed {
        logic [2:0]         sext;
        logic [CH_W-1:0]    chroma;
        logic [CH_W-1:0]    luma;
        logic signed [12:0] x;
    } t_xbeat;

endpackage

[hdl/h2r_if.sv]
// ----------------------------------------------------------------------------
// h2r_if
// Valid/ready channels for HCY input beats and RGB output beats.
// ----------------------------------------------------------------------------
interface h2r_hcy_if;
    import h2r_pkg::*;

    logic             valid;
    logic             ready;
    logic [HUE_W-1:0] hue;
    logic [CH_W-1:0]  chroma;
    logic [CH_W-1:0]  luma;

    modport source (output valid, output hue, output chroma, output luma, input ready);
    modport sink   (input valid, input hue, input chroma, input luma, output ready);
endinterface

interface h2r_rgb_if;
    import h2r_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

[hdl/hcy_to_rgb_converter_top.sv]
// ----------------------------------------------------------------------------
// hcy_to_rgb_converter_top
// Hue/chroma/luma to 12-bit RGB conversion, five-stage pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   i_pix carries one hue/chroma/luma beat per valid/ready handshake;
//   o_rgb returns one red/green/blue beat for every input beat, in order.
//   Throughput: one beat per clock cycle while o_rgb.ready is high.
//   Pipeline: five register stages; an accepted beat passes through them
//   in order and leaves on o_rgb from the last one. The stages
//   are: triangle weight, chroma multiply, channel weights, luma offset,
//   clamp and output register.
//   Each stage has its own valid bit and loads when it is empty or the next
//   stage loads, so bubbles close up and a stalled receiver holds o_rgb
//   steady while up to four more beats are still taken in.
//   Hue codes 24576 and above give luma on all three channels.
//   Reset (i_rst_n low, synchronous) empties all stages; data registers
//   are not reset.
// ----------------------------------------------------------------------------
module hcy_to_rgb_converter_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    h2r_hcy_if.sink    i_pix,
    h2r_rgb_if.source  o_rgb
);
    import h2r_pkg::*;

    logic   s_x_valid;
    logic   s_x_ready;
    t_xbeat s_x;

    h2r_chroma_stage u_chroma (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pix     (i_pix),
        .o_x_valid (s_x_valid),
        .i_x_ready (s_x_ready),
        .o_x       (s_x)
    );

    h2r_luma_stage u_luma (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_x_valid (s_x_valid),
        .o_x_ready (s_x_ready),
        .i_x       (s_x),
        .o_rgb     (o_rgb)
    );

endmodule

[hdl/h2r_chroma_stage.sv]
// ----------------------------------------------------------------------------
// h2r_chroma_stage
// Two pipeline stages: triangle weight from the hue, then X = C * weight >>> 12.
// ----------------------------------------------------------------------------
module h2r_chroma_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    h2r_hcy_if.sink         i_pix,
    output logic            o_x_valid,
    input  logic            i_x_ready,
    output h2r_pkg::t_xbeat o_x
);
    import h2r_pkg::*;

    logic                r_v1;
    logic [2:0]          r_sext1;
    logic [CH_W-1:0]     r_c1;
    logic [CH_W-1:0]     r_l1;
    logic signed [12:0]  r_t1;
    logic                r_v2;
    t_xbeat              r_x2;

    logic                s_en1;
    logic                s_en2;
    logic signed [13:0]  s_dif;
    logic [12:0]         s_absd;
    logic signed [13:0]  s_t;
    logic signed [25:0]  s_prod;

    always_comb begin
        s_en2       = !r_v2 || i_x_ready;
        s_en1       = !r_v1 || s_en2;
        i_pix.ready = s_en1;
    end

    always_comb begin
        s_dif  = signed'({1'b0, i_pix.hue[12:0]}) - FULL_S;
        s_absd = s_dif[13] ? 13'(-s_dif) : s_dif[12:0];
        s_t    = FULL_S - signed'({1'b0, s_absd});
        s_prod = signed'({1'b0, r_c1}) * r_t1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (s_en1) begin
                r_v1 <= i_pix.valid;
            end
            if (s_en2) begin
                r_v2 <= r_v1;
            end
        end
        if (s_en1) begin
            r_sext1 <= i_pix.hue[14:12];
            r_c1    <= i_pix.chroma;
            r_l1    <= i_pix.luma;
            r_t1    <= s_t[12:0];
        end
        if (s_en2) begin
            r_x2.sext   <= r_sext1;
            r_x2.chroma <= r_c1;
            r_x2.luma   <= r_l1;
            r_x2.x      <= s_prod[24:12];
        end
    end

    assign o_x_valid = r_v2;
    assign o_x       = r_x2;

endmodule

[hdl/h2r_luma_stage.sv]
// ----------------------------------------------------------------------------
// h2r_luma_stage
// Three pipeline stages: channel placement and weights, luma offset, clamp.
// ----------------------------------------------------------------------------
module h2r_luma_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_x_valid,
    output logic            o_x_ready,
    input  h2r_pkg::t_xbeat i_x,
    h2r_rgb_if.source       o_rgb
);
    import h2r_pkg::*;

    logic                r_v3;
    logic signed [12:0]  r_r3;
    logic signed [12:0]  r_g3;
    logic signed [12:0]  r_b3;
    logic signed [24:0]  r_pr3;
    logic signed [24:0]  r_pg3;
    logic signed [24:0]  r_pb3;
    logic [CH_W-1:0]     r_l3;
    logic                r_v4;
    logic signed [12:0]  r_r4;
    logic signed [12:0]  r_g4;
    logic signed [12:0]  r_b4;
    logic signed [13:0]  r_m4;
    logic                r_v5;
    logic [CH_W-1:0]     r_red;
    logic [CH_W-1:0]     r_green;
    logic [CH_W-1:0]     r_blue;

    logic                s_en3;
    logic                s_en4;
    logic                s_en5;
    logic signed [12:0]  s_c;
    logic signed [12:0]  s_r;
    logic signed [12:0]  s_g;
    logic signed [12:0]  s_b;
    logic signed [25:0]  s_sum;
    logic signed [13:0]  s_m;

    function automatic logic [CH_W-1:0] clamp_ch(input logic signed [14:0] v);
        logic [CH_W-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > signed'({3'b0, CH_MAX})) begin
            res = CH_MAX;
        end else begin
            res = v[CH_W-1:0];
        end
        return res;
    endfunction

    always_comb begin
        s_en5     = !r_v5 || o_rgb.ready;
        s_en4     = !r_v4 || s_en5;
        s_en3     = !r_v3 || s_en4;
        o_x_ready = s_en3;
    end

    always_comb begin
        s_c = signed'({1'b0, i_x.chroma});
        s_r = '0;
        s_g = '0;
        s_b = '0;
        unique case (i_x.sext)
            SEXT_RY: begin s_r = s_c;   s_g = i_x.x; end
            SEXT_YG: begin s_r = i_x.x; s_g = s_c;   end
            SEXT_GC: begin s_g = s_c;   s_b = i_x.x; end
            SEXT_CB: begin s_g = i_x.x; s_b = s_c;   end
            SEXT_BM: begin s_r = i_x.x; s_b = s_c;   end
            SEXT_MR: begin s_r = s_c;   s_b = i_x.x; end
            default: begin end
        endcase
        s_sum = 26'(r_pr3) + 26'(r_pg3) + 26'(r_pb3);
        s_m   = signed'({2'b0, r_l3}) - s_sum[25:12];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (s_en3) begin
                r_v3 <= i_x_valid;
            end
            if (s_en4) begin
                r_v4 <= r_v3;
            end
            if (s_en5) begin
                r_v5 <= r_v4;
            end
        end
        if (s_en3) begin
            r_r3  <= s_r;
            r_g3  <= s_g;
            r_b3  <= s_b;
            r_pr3 <= s_r * W_RED;
            r_pg3 <= s_g * W_GREEN;
            r_pb3 <= s_b * W_BLUE;
            r_l3  <= i_x.luma;
        end
        if (s_en4) begin
            r_r4 <= r_r3;
            r_g4 <= r_g3;
            r_b4 <= r_b3;
            r_m4 <= s_m;
        end
        if (s_en5) begin
            r_red   <= clamp_ch(15'(r_r4) + 15'(r_m4));
            r_green <= clamp_ch(15'(r_g4) + 15'(r_m4));
            r_blue  <= clamp_ch(15'(r_b4) + 15'(r_m4));
        end
    end

    assign o_rgb.valid = r_v5;
    assign o_rgb.red   = r_red;
    assign o_rgb.green = r_green;
    assign o_rgb.blue  = r_blue;

endmodule

[hdl/h2r_checker.sv]
// ----------------------------------------------------------------------------
// h2r_checker
// Port-level checks of the converter: reset, stall behavior and latency.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module h2r_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [35:0] i_out_data
);

    `H2R_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !i_out_valid, "output valid after reset")

    `H2R_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data), "stalled output beat changed")

    `H2R_ASSERT(a_flow, i_clk, i_rst_n, i_out_ready |-> i_in_ready, "input stalled while output drains")

    `H2R_ASSERT(a_latency, i_clk, i_rst_n, (i_in_valid && i_in_ready && i_out_ready) ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready |=> i_out_valid, "beat missing after five cycles")

endmodule

bind hcy_to_rgb_converter_top h2r_checker u_h2r_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_rgb.valid),
    .i_out_ready (o_rgb.ready),
    .i_out_data  ({o_rgb.red, o_rgb.green, o_rgb.blue})
);
